/* hdl/vc_pkg.sv */
// Shared types and constants for the varint codec.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package vc_pkg;

    localparam int unsigned VC_BYTE_W     = 8;
    localparam int unsigned VC_VALUE_W    = 64;
    localparam int unsigned VC_GROUP_W    = 7;
    localparam int unsigned VC_NARROW_W   = 32;
    localparam int unsigned VC_COUNT_W    = 4;
    localparam int unsigned VC_LIMIT_NARROW = 5;
    localparam int unsigned VC_LIMIT_WIDE   = 10;
    // Groups that fit whole into the 64-bit accumulator; the next one adds one bit.
    localparam int unsigned VC_FULL_GROUPS  = VC_VALUE_W / VC_GROUP_W;

    typedef enum logic [1:0] {
        RK_BYTE  = 2'd0,
        RK_VALUE = 2'd1,
        RK_ERROR = 2'd2
    } vc_result_kind_t;

    typedef struct packed {
        vc_result_kind_t        kind;
        logic [VC_BYTE_W-1:0]   out_byte;
        logic [VC_VALUE_W-1:0]  out_value;
        logic                   last;
    } vc_result_t;

endpackage

/* hdl/vc_decoder.sv */
// Varint byte decoder: gathers seven-bit groups into the accumulator.
// Depends on vc_pkg.
`timescale 1ns / 1ps

module vc_decoder import vc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  take,
    input  logic                  wide,
    input  logic [VC_BYTE_W-1:0]  in_byte,
    output logic                  res_valid,
    output vc_result_t            res
);

    logic [VC_VALUE_W-1:0] acc_reg, acc_next, acc_sum;
    logic [VC_COUNT_W-1:0] cnt_reg, cnt_next;
    logic                  too_long;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end else begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

    assign too_long = wide ? (cnt_reg >= VC_COUNT_W'(VC_LIMIT_WIDE))
                           : (cnt_reg >= VC_COUNT_W'(VC_LIMIT_NARROW));

    // Each byte position owns one slice of the accumulator.
    always_comb begin
        acc_sum = acc_reg;
        for (int i = 0; i < VC_FULL_GROUPS; i++) begin
            if (cnt_reg == VC_COUNT_W'(i)) begin
                acc_sum[i*VC_GROUP_W +: VC_GROUP_W] = acc_reg[i*VC_GROUP_W +: VC_GROUP_W]
                                                      | in_byte[VC_GROUP_W-1:0];
            end
        end
        if (cnt_reg == VC_COUNT_W'(VC_FULL_GROUPS)) begin
            acc_sum[VC_VALUE_W-1] = acc_reg[VC_VALUE_W-1] | in_byte[0];
        end
    end

    always_comb begin
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        res_valid     = 1'b0;
        res.kind      = RK_VALUE;
        res.out_byte  = '0;
        res.out_value = '0;
        res.last      = 1'b1;
        if (take) begin
            if (too_long) begin
                acc_next  = '0;
                cnt_next  = '0;
                res_valid = 1'b1;
                res.kind  = RK_ERROR;
            end else if (in_byte[VC_BYTE_W-1]) begin
                acc_next = acc_sum;
                cnt_next = cnt_reg + 1'b1;
            end else begin
                acc_next  = '0;
                cnt_next  = '0;
                res_valid = 1'b1;
                res.out_value = wide ? acc_sum
                                     : {{(VC_VALUE_W-VC_NARROW_W){1'b0}},
                                        acc_sum[VC_NARROW_W-1:0]};
            end
        end
    end

endmodule

/* hdl/vc_encoder.sv */
// Varint encoder: a 64-bit shift register that drops seven bits per emitted byte.
// Depends on vc_pkg.
`timescale 1ns / 1ps

module vc_encoder import vc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  logic                   advance,
    input  logic                   wide,
    input  logic [VC_VALUE_W-1:0]  in_value,
    output logic                   busy,
    output logic                   res_valid,
    output vc_result_t             res
);

    logic                  busy_reg, busy_next;
    logic [VC_VALUE_W-1:0] rem_reg, rem_next;
    logic [VC_VALUE_W-1:0] src;
    logic                  more;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign src  = busy_reg ? rem_reg
                : (wide ? in_value
                        : {{(VC_VALUE_W-VC_NARROW_W){1'b0}}, in_value[VC_NARROW_W-1:0]});
    assign more = (src[VC_VALUE_W-1:VC_GROUP_W] != '0);

    always_comb begin
        res_valid     = load || (busy_reg && advance);
        res.kind      = RK_BYTE;
        res.out_byte  = {more, src[VC_GROUP_W-1:0]};
        res.out_value = '0;
        res.last      = !more;
        busy_next     = busy_reg;
        rem_next      = rem_reg;
        if (res_valid) begin
            busy_next = more;
            rem_next  = {{VC_GROUP_W{1'b0}}, src[VC_VALUE_W-1:VC_GROUP_W]};
        end
    end

endmodule

/* hdl/varint_codec_core.sv */
// Top level of the varint codec: handshakes and the output register.
// Depends on vc_pkg, vc_decoder and vc_encoder.
`timescale 1ns / 1ps

// Usage
// The input channel (s_*) carries one item per transfer: s_kind 0 hands in one
// encoded byte on s_in_byte, s_kind 1 hands in one value on s_in_value. s_wide
// selects 32-bit or 64-bit varints for that item.
// The result channel (m_*) carries one result per transfer: an encoded byte,
// a decoded value or a too-long error, with m_last on the final result of an item.
// A decode byte's result, if any, is shown on the cycle after the input
// transfer, and the next byte may follow at once, so decode runs at one byte
// per cycle while the receiver does not stall and the encoder is idle.
// An encode item yields 1 to 10 output bytes: the encoder's shift register
// releases seven bits per cycle while the output slot is free, and s_ready
// stays low until the last byte has left the shift register.
// If the receiver stalls, the output register holds its result and s_ready
// falls until that result is taken; nothing is lost or repeated.
// Reset clears the decoder, the encoder and the output valid flag; a value
// half gathered before reset is discarded.

module varint_codec_core import vc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_kind,
    input  logic                   s_wide,
    input  logic [VC_BYTE_W-1:0]   s_in_byte,
    input  logic [VC_VALUE_W-1:0]  s_in_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_result_kind,
    output logic [VC_BYTE_W-1:0]   m_out_byte,
    output logic [VC_VALUE_W-1:0]  m_out_value,
    output logic                   m_last
);

    logic       m_valid_reg, m_valid_next;
    vc_result_t out_reg, out_next;
    logic       slot_free;
    logic       s_take;
    logic       enc_busy, enc_valid, dec_valid;
    vc_result_t enc_res, dec_res;

    // The output slot can take a new result when empty or when being drained.
    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = slot_free && !enc_busy;
    assign s_take    = s_valid && s_ready;

    vc_decoder u_decoder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (s_take && !s_kind),
        .wide      (s_wide),
        .in_byte   (s_in_byte),
        .res_valid (dec_valid),
        .res       (dec_res)
    );

    vc_encoder u_encoder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (s_take && s_kind),
        .advance   (slot_free),
        .wide      (s_wide),
        .in_value  (s_in_value),
        .busy      (enc_busy),
        .res_valid (enc_valid),
        .res       (enc_res)
    );

    // The two sources never fire together: the encoder only loads when idle,
    // and while it is busy no decode byte is accepted.
    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (slot_free) begin
            m_valid_next = dec_valid || enc_valid;
            out_next     = enc_valid ? enc_res : dec_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = out_reg.kind;
    assign m_out_byte    = out_reg.out_byte;
    assign m_out_value   = out_reg.out_value;
    assign m_last        = out_reg.last;

endmodule
